>>> rtl/core/lbp_pkg.sv
// Shared types and constants of the loop branch predictor.
// Used by lbp_index, lbp_lfsr and the top level in rtl/core; has no dependencies of its own.
`default_nettype none

package lbp_pkg;

    localparam int ADDR_W     = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int CNT_W      = 10;
    localparam int WAY_OUT_W  = 2;

    // Trip counts below this value are never trusted.
    localparam int MIN_TRIP = 3;

    localparam logic [15:0] LFSR_MASK = 16'hB400;
    localparam logic [15:0] LFSR_SEED = 16'h0001;

    typedef enum logic [1:0] {
        CMD_PREDICT = 2'd0,
        CMD_ADVANCE = 2'd1,
        CMD_COMMIT  = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USE_DIRECTION_BIT   = 3'd0,
        CFG_USE_HASHING         = 3'd1,
        CFG_USE_SPECULATION     = 3'd2,
        CFG_RESTRICT_ALLOCATION = 3'd3,
        CFG_INST_SHIFT          = 3'd4,
        CFG_INITIAL_ITERATION   = 3'd5,
        CFG_INITIAL_AGE         = 3'd6,
        CFG_AGE_RESET_ON_FREE   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] branch_address;
        logic              taken;
        logic              squash_recovery;
        logic              other_prediction;
        logic              final_prediction;
    } req_t;

    typedef struct packed {
        logic                 loop_prediction;
        logic                 prediction_valid;
        logic                 hit;
        logic [WAY_OUT_W-1:0] hit_way;
        logic [CNT_W-1:0]     iteration_count;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/core/lbp_index.sv
// Set index, hash bits and tag derivation from a branch address.
// Depends on lbp_pkg for the address width.
`default_nettype none

module lbp_index #(
    parameter int LOG_ENTRIES = 6,
    parameter int LOG_WAYS    = 2,
    parameter int TAG_BITS    = 14
) (
    input  wire logic [lbp_pkg::ADDR_W-1:0]  addr,
    input  wire logic [1:0]                  shift,
    input  wire logic                        hashing,
    output logic [LOG_ENTRIES-LOG_WAYS-1:0]  set_idx,
    output logic [LOG_ENTRIES-LOG_WAYS-1:0]  low_bits,
    output logic [TAG_BITS-1:0]              tag
);

    localparam int SET_BITS = LOG_ENTRIES - LOG_WAYS;

    logic [lbp_pkg::ADDR_W-1:0] p;
    logic [lbp_pkg::ADDR_W-1:0] t;
    logic [lbp_pkg::ADDR_W-1:0] mix;
    logic [lbp_pkg::ADDR_W-1:0] t_hash;
    logic [lbp_pkg::ADDR_W-1:0] t_plain;

    always_comb
    begin
        p       = addr >> shift;
        t       = addr >> SET_BITS;
        mix     = p ^ addr;
        t_hash  = t ^ (t >> TAG_BITS);
        t_plain = addr >> (SET_BITS + 32'(shift));
        if (hashing)
        begin
            set_idx  = mix[SET_BITS-1:0];
            low_bits = t[SET_BITS-1:0];
            tag      = t_hash[TAG_BITS-1:0];
        end
        else
        begin
            set_idx  = p[SET_BITS-1:0];
            low_bits = '0;
            tag      = t_plain[TAG_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lbp_lfsr.sv
// Sixteen-bit Galois LFSR that picks ways for allocation.
// Depends on lbp_pkg for the feedback mask and the seed.
`default_nettype none

module lbp_lfsr (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step_one,
    input  wire logic        step_two,
    output logic [15:0]      draw_one,
    output logic [15:0]      draw_two
);

    logic [15:0] lfsr_reg;
    logic [15:0] lfsr_next;

    function automatic logic [15:0] lfsr_step(input logic [15:0] s);
        logic [15:0] n;
        n = s >> 1;
        if (s[0])
        begin
            n = n ^ lbp_pkg::LFSR_MASK;
        end
        return n;
    endfunction

    assign draw_one = lfsr_step(lfsr_reg);
    assign draw_two = lfsr_step(draw_one);

    always_comb
    begin
        lfsr_next = lfsr_reg;
        if (step_two)
        begin
            lfsr_next = draw_two;
        end
        else if (step_one)
        begin
            lfsr_next = draw_one;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= lbp_pkg::LFSR_SEED;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lbp_table.sv
// Loop table storage with one read and one write port, a registered read and per-entry valid bits.
// An entry never written since reset reads as all zeros. No package dependency.
`default_nettype none

module lbp_table #(
    parameter int ADDR_BITS = 6,
    parameter int WIDTH     = 51
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]          rd_data,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] data_reg;
    logic             hit_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            hit_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_valid_reg ? data_reg : '0;

endmodule

`default_nettype wire

>>> rtl/core/loop_branch_predictor_top.sv
// Loop branch predictor top level: configuration, way-walk sequencer and training.
// Depends on lbp_pkg, lbp_index, lbp_lfsr and lbp_table.
//
//   port group   direction  handshake          payload
//   req          in         req_valid/req_stall lbp_pkg::req_t
//   res          out        res_valid/res_stall lbp_pkg::res_t
//   cfg          in         cfg_write          cfg_index, cfg_data
//
// A request walks the ways of its set through the table, a read state and a check
// state per way, until a tag matches or the last way is checked; a request with
// no command skips the walk. It then finishes and the sequencer returns to idle;
// a commit miss that allocates adds a draw state and a read and check per way tried.
// Reset clears the control state and marks every table entry as zero.
// A new request is taken only while the sequencer is idle; a finished result
// waits in the output register, and the walk holds before its final step while
// an earlier result is still stalled.
`default_nettype none

module loop_branch_predictor_top #(
    parameter int LOG_ENTRIES = 6,
    parameter int LOG_WAYS    = 2,
    parameter int TAG_BITS    = 14,
    parameter int ITER_BITS   = 10,
    parameter int AGE_BITS    = 3,
    parameter int CONF_BITS   = 2
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire lbp_pkg::req_t                   req_data,
    output logic                                 res_valid,
    input  wire logic                            res_stall,
    output lbp_pkg::res_t                        res_data,
    input  wire logic                            cfg_write,
    input  wire logic [lbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lbp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SET_BITS = LOG_ENTRIES - LOG_WAYS;
    localparam int NWAYS    = 1 << LOG_WAYS;
    localparam int WAY_W    = (LOG_WAYS > 0) ? LOG_WAYS : 1;
    localparam int ENTRY_W  = TAG_BITS + 3 * ITER_BITS + AGE_BITS + CONF_BITS + 2;
    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(NWAYS - 1);
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic [ITER_BITS-1:0] trip;
        logic [ITER_BITS-1:0] iter;
        logic [ITER_BITS-1:0] iter_spec;
        logic [AGE_BITS-1:0]  age;
        logic [CONF_BITS-1:0] conf;
        logic                 dir;
        logic                 use_spec;
    } entry_t;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_READ   = 7'b0000010,
        S_CHECK  = 7'b0000100,
        S_DRAW   = 7'b0001000,
        S_AREAD  = 7'b0010000,
        S_ACHECK = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    // Configuration registers.
    logic       use_dir_reg;
    logic       use_hash_reg;
    logic       use_spec_reg;
    logic       restrict_reg;
    logic [1:0] shift_reg;
    logic [9:0] init_iter_reg;
    logic [2:0] init_age_reg;
    logic       age_clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_dir_reg   <= 1'b0;
            use_hash_reg  <= 1'b0;
            use_spec_reg  <= 1'b1;
            restrict_reg  <= 1'b0;
            shift_reg     <= 2'd1;
            init_iter_reg <= '0;
            init_age_reg  <= 3'd7;
            age_clr_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (lbp_pkg::cfg_idx_t'(cfg_index))
                lbp_pkg::CFG_USE_DIRECTION_BIT:   use_dir_reg   <= cfg_data[0];
                lbp_pkg::CFG_USE_HASHING:         use_hash_reg  <= cfg_data[0];
                lbp_pkg::CFG_USE_SPECULATION:     use_spec_reg  <= cfg_data[0];
                lbp_pkg::CFG_RESTRICT_ALLOCATION: restrict_reg  <= cfg_data[0];
                lbp_pkg::CFG_INST_SHIFT:          shift_reg     <= cfg_data[1:0];
                lbp_pkg::CFG_INITIAL_ITERATION:   init_iter_reg <= cfg_data;
                lbp_pkg::CFG_INITIAL_AGE:         init_age_reg  <= cfg_data[2:0];
                lbp_pkg::CFG_AGE_RESET_ON_FREE:   age_clr_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    state_t               state_reg, state_next;
    lbp_pkg::req_t        req_reg, req_next;
    logic [WAY_W-1:0]     way_reg, way_next;
    logic [WAY_W-1:0]     tries_reg, tries_next;
    lbp_pkg::res_t        pend_reg, pend_next;
    logic                 res_valid_reg, res_valid_next;
    lbp_pkg::res_t        res_data_reg, res_data_next;

    logic [SET_BITS-1:0]  set_idx;
    logic [SET_BITS-1:0]  low_bits;
    logic [TAG_BITS-1:0]  tag;

    lbp_index #(
        .LOG_ENTRIES (LOG_ENTRIES),
        .LOG_WAYS    (LOG_WAYS),
        .TAG_BITS    (TAG_BITS)
    ) u_index (
        .addr     (req_reg.branch_address),
        .shift    (shift_reg),
        .hashing  (use_hash_reg),
        .set_idx  (set_idx),
        .low_bits (low_bits),
        .tag      (tag)
    );

    logic        step_one, step_two;
    logic [15:0] draw_one, draw_two;

    lbp_lfsr u_lfsr (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_one (step_one),
        .step_two (step_two),
        .draw_one (draw_one),
        .draw_two (draw_two)
    );

    logic                   rd_en;
    logic [LOG_ENTRIES-1:0] slot;
    logic [ENTRY_W-1:0]     rd_raw;
    logic                   wr_en;
    entry_t                 wr_entry;
    entry_t                 e;

    lbp_table #(
        .ADDR_BITS (LOG_ENTRIES),
        .WIDTH     (ENTRY_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (slot),
        .rd_data (rd_raw),
        .wr_en   (wr_en),
        .wr_addr (slot),
        .wr_data (wr_entry)
    );

    assign e = entry_t'(rd_raw);

    // Table slot of the current way; hashing flips set bits per way.
    logic [SET_BITS-1:0] set_way;
    always_comb
    begin
        set_way = set_idx ^ (use_hash_reg ? (low_bits >> way_reg) : '0);
        slot    = (LOG_ENTRIES'(set_way) << LOG_WAYS)
                | LOG_ENTRIES'(way_reg & LAST_WAY);
    end

    // Lookup of the entry just read.
    logic                 spec_mode;
    logic                 body;
    logic                 conf_full;
    logic                 match;
    logic [ITER_BITS-1:0] look_count;
    logic                 look_pred;
    logic                 look_valid;
    logic [ITER_BITS:0]   count_inc;
    logic                 cmd_commit;
    logic                 cmd_advance;

    always_comb
    begin
        cmd_commit  = req_reg.command == lbp_pkg::CMD_COMMIT;
        cmd_advance = req_reg.command == lbp_pkg::CMD_ADVANCE;
        spec_mode   = !cmd_commit && use_spec_reg;
        body        = use_dir_reg ? e.dir : 1'b1;
        conf_full   = &e.conf;
        match       = e.tag == tag;
        look_count  = spec_mode ? e.iter_spec : e.iter;
        count_inc   = {1'b0, look_count} + 1'b1;
        look_pred   = (count_inc == {1'b0, e.trip}) ? !body : body;
        look_valid  = spec_mode ? (conf_full && e.use_spec) : conf_full;
    end

    // Speculative advance of the hit entry.
    entry_t adv_entry;
    logic   loop_end;
    always_comb
    begin
        adv_entry = e;
        loop_end  = use_dir_reg ? (req_reg.taken != e.dir) : !req_reg.taken;
        adv_entry.iter_spec = loop_end ? '0 : e.iter_spec + 1'b1;
        if (req_reg.squash_recovery)
        begin
            adv_entry.use_spec = loop_end;
        end
    end

    // Commit training of the hit entry.
    entry_t trn;
    logic   tk;
    always_comb
    begin
        trn = e;
        tk  = req_reg.taken;
        if (look_valid)
        begin
            if (tk != look_pred)
            begin
                trn.trip     = '0;
                trn.age      = '0;
                trn.conf     = '0;
                trn.use_spec = 1'b0;
            end
            else if (look_pred != req_reg.other_prediction && trn.age < AGE_MAX)
            begin
                trn.age = trn.age + 1'b1;
            end
        end
        trn.iter = trn.iter + 1'b1;
        if (trn.iter > trn.trip)
        begin
            trn.conf = '0;
            if (trn.trip != '0)
            begin
                trn.conf     = '0;
                trn.trip     = '0;
                trn.use_spec = 1'b0;
                if (age_clr_reg)
                begin
                    trn.age = '0;
                end
            end
        end
        if (tk != body)
        begin
            if (trn.iter == trn.trip)
            begin
                if (32'(trn.trip) < lbp_pkg::MIN_TRIP)
                begin
                    trn.conf     = '0;
                    trn.trip     = '0;
                    trn.use_spec = 1'b0;
                    if (age_clr_reg)
                    begin
                        trn.age = '0;
                    end
                end
                else if (!(&trn.conf))
                begin
                    trn.conf = trn.conf + 1'b1;
                end
            end
            else if (trn.trip == '0)
            begin
                trn.conf = '0;
                trn.trip = trn.iter;
            end
            else
            begin
                trn.conf     = '0;
                trn.trip     = '0;
                trn.use_spec = 1'b0;
                if (age_clr_reg)
                begin
                    trn.age = '0;
                end
            end
            trn.iter = '0;
        end
        else if (trn.iter == trn.trip)
        begin
            trn.conf     = '0;
            trn.trip     = '0;
            trn.use_spec = 1'b0;
            if (age_clr_reg)
            begin
                trn.age = '0;
            end
        end
    end

    // Freshly allocated entry and the aged-down victim candidate.
    entry_t      new_entry;
    entry_t      aged_entry;
    logic [31:0] iter_ext;
    logic [31:0] age_ext;
    always_comb
    begin
        iter_ext            = 32'(init_iter_reg);
        age_ext             = 32'(init_age_reg);
        new_entry.tag       = tag;
        new_entry.trip      = '0;
        new_entry.iter      = iter_ext[ITER_BITS-1:0];
        new_entry.iter_spec = iter_ext[ITER_BITS-1:0];
        new_entry.age       = age_ext[AGE_BITS-1:0];
        new_entry.conf      = '0;
        new_entry.dir       = !req_reg.taken;
        new_entry.use_spec  = 1'b0;
        aged_entry          = e;
        aged_entry.age      = e.age - 1'b1;
    end

    logic        alloc_wanted;
    logic [7:0]  way_ext;
    logic [31:0] cnt_ext;
    logic [WAY_W-1:0] first_way;

    always_comb
    begin
        alloc_wanted = use_dir_reg ? (req_reg.final_prediction != req_reg.taken)
                                   : req_reg.taken;
        way_ext      = 8'(way_reg);
        cnt_ext      = 32'(look_count);
        first_way    = draw_two[WAY_W-1:0] & LAST_WAY;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        way_next       = way_reg;
        tries_next     = tries_reg;
        pend_next      = pend_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_entry       = e;
        step_one       = 1'b0;
        step_two       = 1'b0;
        req_stall      = state_reg != S_IDLE;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next  = req_data;
                    way_next  = '0;
                    pend_next = '0;
                    if (req_data.command == lbp_pkg::CMD_NONE)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (match)
                begin
                    pend_next.loop_prediction  = look_pred;
                    pend_next.prediction_valid = look_valid;
                    pend_next.hit              = 1'b1;
                    pend_next.hit_way          = way_ext[lbp_pkg::WAY_OUT_W-1:0];
                    pend_next.iteration_count  = cnt_ext[lbp_pkg::CNT_W-1:0];
                    if (cmd_advance)
                    begin
                        wr_en    = 1'b1;
                        wr_entry = adv_entry;
                    end
                    else if (cmd_commit)
                    begin
                        wr_en    = 1'b1;
                        wr_entry = trn;
                    end
                    state_next = S_FINISH;
                end
                else if (way_reg == LAST_WAY)
                begin
                    if (cmd_commit && alloc_wanted)
                    begin
                        state_next = S_DRAW;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    way_next   = way_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_DRAW:
            begin
                // The first draw gates allocation when it is restricted, the second picks the first way.
                if (restrict_reg && draw_one[1:0] != 2'b00)
                begin
                    step_one   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    step_two   = 1'b1;
                    way_next   = first_way;
                    tries_next = '0;
                    state_next = S_AREAD;
                end
            end
            S_AREAD:
            begin
                rd_en      = 1'b1;
                state_next = S_ACHECK;
            end
            S_ACHECK:
            begin
                wr_en = 1'b1;
                if (e.age == '0)
                begin
                    wr_entry   = new_entry;
                    state_next = S_FINISH;
                end
                else
                begin
                    wr_entry = aged_entry;
                    if (restrict_reg || tries_reg == LAST_WAY)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        way_next   = (way_reg + 1'b1) & LAST_WAY;
                        tries_next = tries_reg + 1'b1;
                        state_next = S_AREAD;
                    end
                end
            end
            S_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    res_data_next  = pend_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        way_reg      <= way_next;
        tries_reg    <= tries_next;
        pend_reg     <= pend_next;
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

`default_nettype wire

>>> tb/tb_loop_branch_predictor_top.sv
// Self-checking testbench for the loop branch predictor top level.
// Depends on lbp_pkg and loop_branch_predictor_top; a behavioral table model predicts each result.
`default_nettype none

module tb_loop_branch_predictor_top;

    typedef struct packed {
        logic       hit;
        logic       pred;
        logic       valid;
        logic [1:0] way;
        logic [5:0] slot;
        logic [9:0] count;
    } way_hit_t;

    logic                              clk;
    logic                              rst_n;
    logic                              req_valid;
    logic                              req_stall;
    lbp_pkg::req_t                     req_data;
    logic                              res_valid;
    logic                              res_stall;
    lbp_pkg::res_t                     res_data;
    logic                              cfg_write;
    logic [lbp_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [lbp_pkg::CFG_DATA_W-1:0]    cfg_data;

    // Model of the table and the allocation LFSR.
    logic [13:0] tbl_tag [64];
    logic [9:0]  tbl_trip [64];
    logic [9:0]  tbl_iter [64];
    logic [9:0]  tbl_ispec [64];
    logic [2:0]  tbl_age [64];
    logic [1:0]  tbl_conf [64];
    logic        tbl_dir [64];
    logic        tbl_uspec [64];
    logic [15:0] alloc_lfsr;

    logic       c_dir, c_hash, c_spec, c_restrict, c_age_clear;
    logic [1:0] c_shift;
    logic [9:0] c_init_iter;
    logic [2:0] c_init_age;

    lbp_pkg::req_t  pending_reqs[$];
    lbp_pkg::res_t  expected_results[$];
    int    errors = 0;
    int    idle_pct;
    int    stall_pct;
    int    quiet_cycles;
    logic [47:0] addr_pool[8];

    loop_branch_predictor_top DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
        .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic logic [15:0] draw_lfsr();
        logic lsb;
        lsb = alloc_lfsr[0];
        alloc_lfsr = alloc_lfsr >> 1;
        if (lsb)
            alloc_lfsr = alloc_lfsr ^ lbp_pkg::LFSR_MASK;
        return alloc_lfsr;
    endfunction

    function automatic logic [5:0] slot_at(logic [5:0] base, logic [3:0] lowb, int w);
        logic [3:0] sh;
        logic [5:0] b;
        sh = lowb >> w;
        b = c_hash ? (base ^ {sh, 2'b00}) : base;
        return b + 6'(w);
    endfunction

    function automatic way_hit_t find_way(logic [5:0] base, logic [3:0] lowb,
                                          logic [13:0] tag, logic spec);
        way_hit_t r;
        logic [5:0] s;
        logic body;
        logic sat;
        r = '0;
        for (int w = 0; w < 4; w++)
        begin
            s = slot_at(base, lowb, w);
            if (tbl_tag[s] == tag)
            begin
                body = c_dir ? tbl_dir[s] : 1'b1;
                sat = (tbl_conf[s] == 2'd3);
                r.hit = 1'b1;
                r.way = 2'(w);
                r.slot = s;
                r.valid = spec ? (sat && tbl_uspec[s]) : sat;
                r.count = spec ? tbl_ispec[s] : tbl_iter[s];
                r.pred = ({22'b0, r.count} + 32'd1 == {22'b0, tbl_trip[s]}) ? !body : body;
                return r;
            end
        end
        return r;
    endfunction

    function automatic void release_entry(logic [5:0] s);
        tbl_conf[s] = 0;
        tbl_trip[s] = 0;
        tbl_uspec[s] = 0;
        if (c_age_clear)
            tbl_age[s] = 0;
    endfunction

    function automatic void train_entry(way_hit_t lk, logic tk, logic other);
        logic [5:0] s;
        logic body;
        s = lk.slot;
        body = c_dir ? tbl_dir[s] : 1'b1;
        if (lk.valid)
        begin
            if (tk != lk.pred)
            begin
                tbl_trip[s] = 0;
                tbl_age[s] = 0;
                tbl_conf[s] = 0;
                tbl_uspec[s] = 0;
            end
            else if (lk.pred != other && tbl_age[s] < 3'd7)
                tbl_age[s] = tbl_age[s] + 1;
        end
        tbl_iter[s] = tbl_iter[s] + 1;
        if (tbl_iter[s] > tbl_trip[s])
        begin
            tbl_conf[s] = 0;
            if (tbl_trip[s] != 0)
                release_entry(s);
        end
        if (tk != body)
        begin
            if (tbl_iter[s] == tbl_trip[s])
            begin
                if (tbl_trip[s] < lbp_pkg::MIN_TRIP)
                    release_entry(s);
                else if (tbl_conf[s] < 2'd3)
                    tbl_conf[s] = tbl_conf[s] + 1;
            end
            else if (tbl_trip[s] == 0)
            begin
                tbl_conf[s] = 0;
                tbl_trip[s] = tbl_iter[s];
            end
            else
                release_entry(s);
            tbl_iter[s] = 0;
        end
        else if (tbl_iter[s] == tbl_trip[s])
            release_entry(s);
    endfunction

    function automatic void allocate_entry(logic [5:0] base, logic [3:0] lowb,
                                           logic [13:0] tag, logic tk);
        logic [15:0] gate;
        logic [15:0] first;
        logic [5:0]  s;
        int w;
        gate = draw_lfsr();
        if (gate[1:0] != 2'b00 && c_restrict)
            return;
        first = draw_lfsr();
        for (int i = 0; i < 4; i++)
        begin
            w = (int'(first) + i) & 3;
            s = slot_at(base, lowb, w);
            if (tbl_age[s] == 0)
            begin
                tbl_dir[s] = !tk;
                tbl_tag[s] = tag;
                tbl_trip[s] = 0;
                tbl_age[s] = c_init_age;
                tbl_conf[s] = 0;
                tbl_iter[s] = c_init_iter;
                tbl_ispec[s] = c_init_iter;
                tbl_uspec[s] = 0;
                return;
            end
            tbl_age[s] = tbl_age[s] - 1;
            if (c_restrict)
                return;
        end
    endfunction

    // Computes the result of one request and updates the table model.
    function automatic lbp_pkg::res_t predict_loop_result(lbp_pkg::req_t r);
        logic [63:0]   a, p, t, tt;
        logic [5:0]    base;
        logic [3:0]    lowb;
        logic [13:0]   tag;
        way_hit_t      lk;
        logic          loop_end;
        lbp_pkg::res_t o;
        o = '0;
        if (r.command == lbp_pkg::CMD_NONE)
            return o;
        a = {16'b0, r.branch_address};
        p = a >> c_shift;
        if (c_hash)
        begin
            t = a >> 4;
            p = p ^ a;
            lowb = t[3:0];
            tt = t ^ (t >> 14);
            tag = tt[13:0];
        end
        else
        begin
            lowb = 0;
            tt = a >> (c_shift + 4);
            tag = tt[13:0];
        end
        base = {p[3:0], 2'b00};
        lk = find_way(base, lowb, tag,
                      (r.command == lbp_pkg::CMD_COMMIT) ? 1'b0 : c_spec);
        if (r.command == lbp_pkg::CMD_ADVANCE && lk.hit)
        begin
            loop_end = c_dir ? (r.taken != tbl_dir[lk.slot]) : !r.taken;
            tbl_ispec[lk.slot] = loop_end ? 10'd0 : tbl_ispec[lk.slot] + 1;
            if (r.squash_recovery)
                tbl_uspec[lk.slot] = loop_end;
        end
        else if (r.command == lbp_pkg::CMD_COMMIT)
        begin
            if (lk.hit)
                train_entry(lk, r.taken, r.other_prediction);
            else if (c_dir ? (r.final_prediction != r.taken) : r.taken)
                allocate_entry(base, lowb, tag, r.taken);
        end
        o.loop_prediction = lk.pred;
        o.prediction_valid = lk.valid;
        o.hit = lk.hit;
        o.hit_way = lk.way;
        o.iteration_count = lk.count;
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic add_req(lbp_pkg::cmd_t cmd, logic [47:0] addr, logic tk, logic sq,
                           logic op, logic fp);
        lbp_pkg::req_t r;
        r.command = cmd;
        r.branch_address = addr;
        r.taken = tk;
        r.squash_recovery = sq;
        r.other_prediction = op;
        r.final_prediction = fp;
        pending_reqs.push_back(r);
    endtask

    // One loop of the given trip count, run several times: predict, advance, commit.
    task automatic run_loop(logic [47:0] addr, int trip, int reps);
        logic tk;
        for (int k = 0; k < reps; k++)
            for (int i = 0; i < trip; i++)
            begin
                tk = (i != trip - 1);
                if ($urandom_range(99) < 4)
                    tk = !tk;
                add_req(lbp_pkg::CMD_PREDICT, addr, tk, 1'($urandom_range(1)),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
                add_req(lbp_pkg::CMD_ADVANCE, addr, tk, $urandom_range(99) < 25,
                        1'($urandom_range(1)), 1'($urandom_range(1)));
                add_req(lbp_pkg::CMD_COMMIT, addr, tk, 1'($urandom_range(1)),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
            end
    endtask

    task automatic set_reg(lbp_pkg::cfg_idx_t idx, int v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= lbp_pkg::CFG_DATA_W'(v);
        case (idx)
            lbp_pkg::CFG_USE_DIRECTION_BIT:   c_dir = v[0];
            lbp_pkg::CFG_USE_HASHING:         c_hash = v[0];
            lbp_pkg::CFG_USE_SPECULATION:     c_spec = v[0];
            lbp_pkg::CFG_RESTRICT_ALLOCATION: c_restrict = v[0];
            lbp_pkg::CFG_INST_SHIFT:          c_shift = v[1:0];
            lbp_pkg::CFG_INITIAL_ITERATION:   c_init_iter = v[9:0];
            lbp_pkg::CFG_INITIAL_AGE:         c_init_age = v[2:0];
            default:                          c_age_clear = v[0];
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_all(int d, int h, int s, int r, int sh, int it, int ag, int fr);
        set_reg(lbp_pkg::CFG_USE_DIRECTION_BIT, d);
        set_reg(lbp_pkg::CFG_USE_HASHING, h);
        set_reg(lbp_pkg::CFG_USE_SPECULATION, s);
        set_reg(lbp_pkg::CFG_RESTRICT_ALLOCATION, r);
        set_reg(lbp_pkg::CFG_INST_SHIFT, sh);
        set_reg(lbp_pkg::CFG_INITIAL_ITERATION, it);
        set_reg(lbp_pkg::CFG_INITIAL_AGE, ag);
        set_reg(lbp_pkg::CFG_AGE_RESET_ON_FREE, fr);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic random_phase(int n);
        logic [15:0] low_a, low_b;
        lbp_pkg::cmd_t c;
        @(negedge clk);
        low_a = 16'($urandom);
        low_b = 16'($urandom);
        for (int k = 0; k < 8; k++)
            addr_pool[k] = {32'($urandom), (k < 5) ? low_a : low_b};
        // Mostly well-formed loops on a few colliding addresses, some noise.
        while (pending_reqs.size() < n)
        begin
            if ($urandom_range(99) < 75)
                run_loop(addr_pool[$urandom_range(7)], $urandom_range(6, 2),
                         $urandom_range(4, 1));
            else
            begin
                c = lbp_pkg::cmd_t'($urandom_range(3));
                add_req(c, ($urandom_range(1) ? {16'($urandom), 32'($urandom)}
                                              : addr_pool[$urandom_range(7)]),
                        1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = !clk;
    end

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data <= '0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (req_valid)
                expected_results.push_back(predict_loop_result(req_data));
            if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                req_data <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Result monitor and watchdog.
    always @(posedge clk or negedge rst_n)
    begin
        lbp_pkg::res_t want;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", int'(res_data), 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (res_data.loop_prediction != want.loop_prediction)
                        report_mismatch("loop_prediction", int'(res_data.loop_prediction),
                                        int'(want.loop_prediction));
                    if (res_data.prediction_valid != want.prediction_valid)
                        report_mismatch("prediction_valid",
                                        int'(res_data.prediction_valid),
                                        int'(want.prediction_valid));
                    if (res_data.hit != want.hit)
                        report_mismatch("hit", int'(res_data.hit), int'(want.hit));
                    if (res_data.hit_way != want.hit_way)
                        report_mismatch("hit_way", int'(res_data.hit_way),
                                        int'(want.hit_way));
                    if (res_data.iteration_count != want.iteration_count)
                        report_mismatch("iteration_count",
                                        int'(res_data.iteration_count),
                                        int'(want.iteration_count));
                end
            end
            res_stall <= ($urandom_range(99) < stall_pct);
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= 4000)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < 64; i++)
        begin
            tbl_tag[i] = 0; tbl_trip[i] = 0; tbl_iter[i] = 0; tbl_ispec[i] = 0;
            tbl_age[i] = 0; tbl_conf[i] = 0; tbl_dir[i] = 0; tbl_uspec[i] = 0;
        end
        alloc_lfsr = lbp_pkg::LFSR_SEED;
        c_dir = 0; c_hash = 0; c_spec = 1; c_restrict = 0;
        c_shift = 1; c_init_iter = 0; c_init_age = 7; c_age_clear = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero tag hits after reset, extreme addresses, every command.
        set_all(0, 0, 1, 0, 1, 0, 7, 0);
        @(negedge clk);
        add_req(lbp_pkg::CMD_PREDICT, 48'h0, 0, 0, 0, 0);
        add_req(lbp_pkg::CMD_ADVANCE, 48'h0, 1, 1, 0, 0);
        add_req(lbp_pkg::CMD_ADVANCE, 48'h0, 0, 1, 1, 1);
        add_req(lbp_pkg::CMD_COMMIT, 48'h0, 1, 0, 1, 0);
        add_req(lbp_pkg::CMD_NONE, 48'hFFFF_FFFF_FFFF, 1, 1, 1, 1);
        add_req(lbp_pkg::CMD_PREDICT, 48'hFFFF_FFFF_FFFF, 1, 1, 1, 1);
        add_req(lbp_pkg::CMD_COMMIT, 48'hFFFF_FFFF_FFFF, 1, 1, 1, 1);
        add_req(lbp_pkg::CMD_COMMIT, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0);
        add_req(lbp_pkg::CMD_PREDICT, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0);
        add_req(lbp_pkg::CMD_ADVANCE, 48'hFFFF_FFFF_FFFF, 1, 1, 0, 1);
        add_req(lbp_pkg::CMD_COMMIT, 48'h5555_5555_5555, 1, 0, 0, 1);
        add_req(lbp_pkg::CMD_COMMIT, 48'hAAAA_AAAA_AAAA, 1, 1, 1, 0);
        run_loop(48'h1234_5678_9AB0, 3, 3);
        wait_drained();

        idle_pct = 0;  stall_pct = 0;
        random_phase(150);
        wait_drained();

        set_all(1, 1, 0, 1, 3, 1023, 0, 1);
        idle_pct = 55; stall_pct = 0;
        random_phase(150);
        wait_drained();

        set_all(0, 1, 1, 0, 0, 0, 1, 1);
        idle_pct = 0;  stall_pct = 55;
        random_phase(150);
        wait_drained();

        set_all(1, 0, 1, 0, 2, 5, 7, 0);
        idle_pct = 25; stall_pct = 25;
        random_phase(150);
        wait_drained();

        set_all($urandom_range(1), $urandom_range(1), $urandom_range(1), $urandom_range(1),
                $urandom_range(3), $urandom_range(1023), $urandom_range(7), $urandom_range(1));
        idle_pct = 0;  stall_pct = 0;
        random_phase(150);
        wait_drained();

        set_all(0, 0, 0, 1, 1, 0, 3, 0);
        idle_pct = 25; stall_pct = 25;
        random_phase(100);
        wait_drained();

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/lbp_pkg.sv
rtl/core/lbp_index.sv
rtl/core/lbp_lfsr.sv
rtl/core/lbp_table.sv
rtl/core/loop_branch_predictor_top.sv
tb/tb_loop_branch_predictor_top.sv
